[sv/bfpid_pkg.sv]
// shared types and constants of the burst-fire pid heater controller
package bfpid_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_W   = 36;

    // request kinds
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // phase codes
    localparam logic [1:0] PH_HEAT = 2'd0;
    localparam logic [1:0] PH_READ = 2'd1;
    localparam logic [1:0] PH_IDLE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SETPOINT   = 3'd0;
    localparam logic [2:0] REG_STAND_TEMP = 3'd1;
    localparam logic [2:0] REG_GAIN_P     = 3'd2;
    localparam logic [2:0] REG_GAIN_I     = 3'd3;
    localparam logic [2:0] REG_GAIN_D     = 3'd4;
    localparam logic [2:0] REG_INTEG_CAP  = 3'd5;
    localparam logic [2:0] REG_HALF_CYC   = 3'd6;
    localparam logic [2:0] REG_SCALE      = 3'd7;

    // calibration and control constants
    localparam logic [MUL_B_W-1:0] CAL_GAIN   = 18'd51;
    localparam logic [21:0]        CAL_BIAS   = 22'd163840;
    localparam logic [MUL_B_W-1:0] RECIP_5    = 18'd209716;
    localparam logic [MUL_B_W-1:0] RECIP_25   = 18'd41944;
    localparam logic signed [16:0] CAL_OFFSET = 17'sd4356;
    localparam logic signed [16:0] TEMP_LOW   = 17'sd80;
    localparam logic signed [16:0] TEMP_HIGH  = 17'sd6880;
    localparam logic signed [16:0] TEMP_MAX   = 17'sd32767;
    localparam logic [10:0]        POWER_FULL = 11'd1024;
    localparam logic signed [ACC_W-1:0] SUM_SAT = 36'sd410000;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'b0000_0000_0000_0001,
        ST_TICK_MUL = 16'b0000_0000_0000_0010,
        ST_TICK_FIN = 16'b0000_0000_0000_0100,
        ST_CAL_P    = 16'b0000_0000_0000_1000,
        ST_CAL_RH   = 16'b0000_0000_0001_0000,
        ST_CAL_RL   = 16'b0000_0000_0010_0000,
        ST_CAL_DIV  = 16'b0000_0000_0100_0000,
        ST_CAL_FIN  = 16'b0000_0000_1000_0000,
        ST_PID_E    = 16'b0000_0001_0000_0000,
        ST_PID_P    = 16'b0000_0010_0000_0000,
        ST_PID_I    = 16'b0000_0100_0000_0000,
        ST_PID_D    = 16'b0000_1000_0000_0000,
        ST_PID_S    = 16'b0001_0000_0000_0000,
        ST_PID_DIV  = 16'b0010_0000_0000_0000,
        ST_PID_FIN  = 16'b0100_0000_0000_0000,
        ST_DONE     = 16'b1000_0000_0000_0000
    } t_state;

endpackage

[sv/bfpid_mul.sv]
// shared registered signed-by-unsigned multiplier
module bfpid_mul import bfpid_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic        [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'($signed({1'b0, i_b}));
    end

    assign o_prod = r_prod;

endmodule

[sv/burst_fire_pid_heater_controller.sv]
// Burst-fire PID heater controller top level. One request is taken at a time: s_axis_tready
// is high only while the sequencer is idle. A half-cycle tick runs the multiply and finish
// steps of the tick path; a sample ignored in the heating phase goes straight to the output
// step; an out-of-range sample runs the calibration steps only; and a full calibration plus
// PID step runs the error, gain, sum and divide steps, the divide skipped when the sum is not
// positive or saturates. s_axis_tready rises again as the result register loads. Every
// multiply of the tick, calibration and PID arithmetic goes through one registered 19x18
// multiplier, one product per cycle. A finished result sits in the output
// register while the next request is taken; the sequencer waits in its last step only
// while that register is still full. Configuration writes are taken in any cycle.
module burst_fire_pid_heater_controller import bfpid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // adc_sum[12:0], cj_temp[24:13], stand_sel[25], ext_faults[27:26]
    input  logic [31:0] s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // heater_on[0], phase[2:1], power_level[13:3], measured_temp[29:14],
    // fault_bits[32:30], sample_used[33]
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data
);

    // configuration
    logic [12:0] r_setpoint, r_stand_temp;
    logic [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [14:0] r_integ_cap;
    logic [9:0]  r_half_cyc;
    logic [17:0] r_scale;

    // latched request
    logic               r_op, n_op;
    logic [12:0]        r_adc, n_adc;
    logic signed [11:0] r_amb, n_amb;
    logic               r_stand, n_stand;
    logic [1:0]         r_ext, n_ext;

    // controller state
    t_state             r_state, n_state;
    logic [1:0]         r_phase, n_phase;
    logic [9:0]         r_count, n_count;
    logic [10:0]        r_power, n_power;
    logic [14:0]        r_integ, n_integ;
    logic signed [15:0] r_last, n_last;
    logic signed [15:0] r_temp, n_temp;
    logic               r_rfault, n_rfault;
    logic               r_heater, n_heater;
    logic               r_used, n_used;

    // scratch
    logic [15:0]             r_rl, n_rl;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [15:0]      r_e, n_e;
    logic signed [16:0]      r_d, n_d;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data, n_out_data;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  r_prod;

    bfpid_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (r_prod)
    );

    // datapath temporaries
    logic               ext_heat;
    logic [1:0]         ph1;
    logic [9:0]         cnt1;
    logic [20:0]        tick_sum;
    logic [10:0]        tick_t;
    logic               faulty;
    logic signed [17:0] rh;
    logic [21:0]        cal_y;
    logic [15:0]        q5;
    logic signed [16:0] t17;
    logic [12:0]        target;
    logic signed [16:0] e17;
    logic signed [17:0] integ_sum;
    logic [10:0]        pw_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= 13'd5600;
            r_stand_temp <= 13'd2400;
            r_gain_p     <= 16'd256;
            r_gain_i     <= 16'd51;
            r_gain_d     <= 16'd51;
            r_integ_cap  <= 15'd1600;
            r_half_cyc   <= 10'd100;
            r_scale      <= 18'd121563;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SETPOINT:   r_setpoint   <= i_cfg_data[12:0];
                REG_STAND_TEMP: r_stand_temp <= i_cfg_data[12:0];
                REG_GAIN_P:     r_gain_p     <= i_cfg_data[15:0];
                REG_GAIN_I:     r_gain_i     <= i_cfg_data[15:0];
                REG_GAIN_D:     r_gain_d     <= i_cfg_data[15:0];
                REG_INTEG_CAP:  r_integ_cap  <= i_cfg_data[14:0];
                REG_HALF_CYC:   r_half_cyc   <= i_cfg_data[9:0];
                REG_SCALE:      r_scale      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_adc       = r_adc;
        n_amb       = r_amb;
        n_stand     = r_stand;
        n_ext       = r_ext;
        n_phase     = r_phase;
        n_count     = r_count;
        n_power     = r_power;
        n_integ     = r_integ;
        n_last      = r_last;
        n_temp      = r_temp;
        n_rfault    = r_rfault;
        n_heater    = r_heater;
        n_used      = r_used;
        n_rl        = r_rl;
        n_acc       = r_acc;
        n_e         = r_e;
        n_d         = r_d;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        mul_a       = '0;
        mul_b       = '0;

        ext_heat  = (s_axis_tdata[27:26] != 2'd0) && (r_phase == PH_HEAT);
        ph1       = ext_heat ? PH_IDLE : r_phase;
        cnt1      = ext_heat ? 10'd0 : r_count;
        tick_sum  = r_prod[20:0] + 21'd512;
        tick_t    = tick_sum[20:10];
        faulty    = r_rfault || (r_ext != 2'd0);
        rh        = {{6{r_amb[11]}}, r_amb} + {3'b000, r_prod[30:16]};
        cal_y     = r_acc[21:0] + {16'd0, r_prod[21:16]} + CAL_BIAS;
        q5        = r_prod[35:20];
        t17       = $signed({1'b0, q5}) - CAL_OFFSET;
        target    = r_stand ? r_stand_temp : r_setpoint;
        e17       = $signed({4'b0000, target}) - {r_temp[15], r_temp};
        integ_sum = $signed({3'b000, r_integ}) + {e17[16], e17};
        pw_out    = faulty ? 11'd0 : r_power;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op     = s_axis_tuser;
                    n_adc    = s_axis_tdata[12:0];
                    n_amb    = s_axis_tdata[24:13];
                    n_stand  = s_axis_tdata[25];
                    n_ext    = s_axis_tdata[27:26];
                    n_heater = 1'b0;
                    n_used   = 1'b0;
                    n_phase  = ph1;
                    if (s_axis_tuser == OP_TICK) begin
                        n_count = (cnt1 != 10'h3FF) ? cnt1 + 10'd1 : cnt1;
                        n_state = ST_TICK_MUL;
                    end else begin
                        n_count = cnt1;
                        n_state = (ph1 == PH_HEAT) ? ST_DONE : ST_CAL_P;
                    end
                end
            end
            ST_TICK_MUL: begin
                mul_a   = (r_phase == PH_HEAT) ? {8'd0, r_power}
                                               : {8'd0, POWER_FULL - r_power};
                mul_b   = {8'd0, r_half_cyc};
                n_state = ST_TICK_FIN;
            end
            ST_TICK_FIN: begin
                if (r_phase == PH_HEAT) begin
                    n_heater = !faulty;
                    if ({1'b0, r_count} >= tick_t) begin
                        n_phase = PH_READ;
                        n_count = 10'd0;
                    end
                end else if (r_phase == PH_IDLE) begin
                    if ({1'b0, r_count} >= tick_t) begin
                        n_phase = faulty ? PH_READ : PH_HEAT;
                        n_count = 10'd0;
                    end
                end
                n_state = ST_DONE;
            end
            ST_CAL_P: begin
                mul_a   = {6'd0, r_adc};
                mul_b   = r_scale;
                n_state = ST_CAL_RH;
            end
            ST_CAL_RH: begin
                mul_a   = {rh[17], rh};
                mul_b   = CAL_GAIN;
                n_rl    = r_prod[15:0];
                n_state = ST_CAL_RL;
            end
            ST_CAL_RL: begin
                n_acc   = r_prod[ACC_W-1:0];
                mul_a   = {3'b000, r_rl};
                mul_b   = CAL_GAIN;
                n_state = ST_CAL_DIV;
            end
            ST_CAL_DIV: begin
                mul_a   = {1'b0, cal_y[20:3]};
                mul_b   = RECIP_5;
                n_state = ST_CAL_FIN;
            end
            ST_CAL_FIN: begin
                n_temp  = (t17 > TEMP_MAX) ? 16'sh7FFF : t17[15:0];
                n_used  = 1'b1;
                n_phase = PH_IDLE;
                n_count = 10'd0;
                if (t17 < TEMP_LOW || t17 > TEMP_HIGH) begin
                    n_rfault = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    n_rfault = 1'b0;
                    n_state  = ST_PID_E;
                end
            end
            ST_PID_E: begin
                n_e = e17[15:0];
                if (integ_sum < 18'sd0) begin
                    n_integ = 15'd0;
                end else if (integ_sum > $signed({3'b000, r_integ_cap})) begin
                    n_integ = r_integ_cap;
                end else begin
                    n_integ = integ_sum[14:0];
                end
                n_state = ST_PID_P;
            end
            ST_PID_P: begin
                mul_a   = {{3{r_e[15]}}, r_e};
                mul_b   = {2'b00, r_gain_p};
                n_d     = {r_e[15], r_e} - {r_last[15], r_last};
                n_last  = r_e;
                n_state = ST_PID_I;
            end
            ST_PID_I: begin
                n_acc   = r_prod[ACC_W-1:0];
                mul_a   = {4'd0, r_integ};
                mul_b   = {2'b00, r_gain_i};
                n_state = ST_PID_D;
            end
            ST_PID_D: begin
                n_acc   = r_acc + r_prod[ACC_W-1:0];
                mul_a   = {{2{r_d[16]}}, r_d};
                mul_b   = {2'b00, r_gain_d};
                n_state = ST_PID_S;
            end
            ST_PID_S: begin
                n_acc   = r_acc + r_prod[ACC_W-1:0];
                n_state = ST_PID_DIV;
            end
            ST_PID_DIV: begin
                if (r_acc <= 36'sd0) begin
                    n_power = 11'd0;
                    n_state = ST_DONE;
                end else if (r_acc >= SUM_SAT) begin
                    n_power = POWER_FULL;
                    n_state = ST_DONE;
                end else begin
                    mul_a   = {4'd0, r_acc[18:4]};
                    mul_b   = RECIP_25;
                    n_state = ST_PID_FIN;
                end
            end
            ST_PID_FIN: begin
                n_power = r_prod[30:20];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_power     = pw_out;
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_used, r_ext, r_rfault, r_temp, pw_out,
                                   r_phase, r_heater};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HEAT;
            r_count     <= 10'd0;
            r_power     <= 11'd0;
            r_integ     <= 15'd0;
            r_last      <= 16'sd0;
            r_temp      <= 16'sd0;
            r_rfault    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_power     <= n_power;
            r_integ     <= n_integ;
            r_last      <= n_last;
            r_temp      <= n_temp;
            r_rfault    <= n_rfault;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_adc      <= n_adc;
        r_amb      <= n_amb;
        r_stand    <= n_stand;
        r_ext      <= n_ext;
        r_heater   <= n_heater;
        r_used     <= n_used;
        r_rl       <= n_rl;
        r_acc      <= n_acc;
        r_e        <= n_e;
        r_d        <= n_d;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // the tick path is entered only for a taken tick, never for a taken sample
    a_op_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_MUL) |-> (r_op == OP_TICK))
        else $error("tick path entered for a sample");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    a_fault_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[32:30] != 3'd0)) |-> (m_axis_tdata[13:3] == 11'd0))
        else $error("power left on under a fault");

    a_heater_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> ((m_axis_tdata[32:30] == 3'd0)
                                                && !m_axis_tdata[33]))
        else $error("heater on with a fault or on a sample");

    a_used_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tdata[2:1] == PH_IDLE))
        else $error("used sample did not enter idle phase");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power <= POWER_FULL)
        else $error("power above full scale");

endmodule

[test/tb_burst_fire_pid_heater_controller.sv]
// self-checking testbench of the burst-fire pid heater controller, directed and random traffic
module tb_burst_fire_pid_heater_controller;
    import bfpid_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_ROUND = 240;

    typedef struct {
        logic               op;
        logic [12:0]        adc;
        logic signed [11:0] amb;
        logic               stand;
        logic [1:0]         ext;
    } t_request;

    typedef struct {
        logic               heater;
        logic [1:0]         phase;
        logic [10:0]        power;
        logic signed [15:0] temp;
        logic [2:0]         faults;
        logic               used;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [17:0] i_cfg_data = '0;

    // controller shadow: registers and state
    logic [17:0] cfg_val [8];
    logic [17:0] cfg_plan [8];
    logic [1:0]  m_phase;
    int          m_count;
    int          m_power;
    longint      m_integ;
    longint      m_last_err;
    longint      m_temp;
    bit          m_rdfault;

    t_status predicted_status_q [$];
    int      err_count = 0;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      quiet_cycles = 0;

    burst_fire_pid_heater_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [17:0] reg_mask(input logic [2:0] idx);
        case (idx)
            REG_SETPOINT, REG_STAND_TEMP: return 18'h01FFF;
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: return 18'h0FFFF;
            REG_INTEG_CAP: return 18'h07FFF;
            REG_HALF_CYC: return 18'h003FF;
            default: return 18'h3FFFF;
        endcase
    endfunction

    function automatic t_status predict_controller(input t_request req);
        t_status s;
        longint  n, span, target, r, num, quo, err, drv, sum;
        longint  gp, gi, gd, cap;
        bit      fault_now;
        n   = longint'(cfg_val[REG_HALF_CYC]);
        gp  = longint'(cfg_val[REG_GAIN_P]);
        gi  = longint'(cfg_val[REG_GAIN_I]);
        gd  = longint'(cfg_val[REG_GAIN_D]);
        cap = longint'(cfg_val[REG_INTEG_CAP]);
        s.heater = 1'b0;
        s.used = 1'b0;
        if (req.ext != 2'd0 && m_phase == PH_HEAT) begin
            m_phase = PH_IDLE;
            m_count = 0;
        end
        if (req.op == OP_TICK) begin
            fault_now = m_rdfault || (req.ext != 2'd0);
            if (m_count < 1023) m_count++;
            if (m_phase == PH_HEAT) begin
                span = (longint'(m_power) * n + 512) >> 10;
                s.heater = !fault_now;
                if (m_count >= span) begin
                    m_phase = PH_READ;
                    m_count = 0;
                end
            end else if (m_phase == PH_IDLE) begin
                span = ((1024 - longint'(m_power)) * n + 512) >> 10;
                if (m_count >= span) begin
                    m_phase = fault_now ? PH_READ : PH_HEAT;
                    m_count = 0;
                end
            end
        end else if (m_phase != PH_HEAT) begin
            target = req.stand ? longint'(cfg_val[REG_STAND_TEMP])
                               : longint'(cfg_val[REG_SETPOINT]);
            s.used = 1'b1;
            // calibration, floor division then offset and saturation
            r = longint'(req.amb) * 65536 + longint'(req.adc) * longint'(cfg_val[REG_SCALE]);
            num = 51 * r;
            quo = num / 2621440;
            if (num % 2621440 != 0 && num < 0) quo--;
            m_temp = quo - 260;
            if (m_temp > 32767) m_temp = 32767;
            if (m_temp < -32768) m_temp = -32768;
            if (m_temp < 80 || m_temp > 6880) begin
                m_rdfault = 1'b1;
            end else begin
                m_rdfault = 1'b0;
                err = target - m_temp;
                m_integ = m_integ + err;
                if (m_integ < 0) m_integ = 0;
                if (m_integ > cap) m_integ = cap;
                drv = err - m_last_err;
                sum = gp * err + gi * m_integ + gd * drv;
                m_last_err = err;
                if (sum <= 0) m_power = 0;
                else if (sum / 400 > 1024) m_power = 1024;
                else m_power = int'(sum / 400);
            end
            m_phase = PH_IDLE;
            m_count = 0;
        end
        if (m_rdfault || req.ext != 2'd0) m_power = 0;
        s.phase  = m_phase;
        s.power  = 11'(m_power);
        s.temp   = m_temp[15:0];
        s.faults = {req.ext, m_rdfault};
        return s;
    endfunction

    // adc sum that lands near a wanted temperature under the current scale
    function automatic logic [12:0] adc_for(input longint tgt, input logic signed [11:0] amb);
        longint need;
        if (cfg_val[REG_SCALE] == 18'd0) return 13'($urandom);
        need = ((tgt + 260) * 2621440 / 51 - longint'(amb) * 65536)
               / longint'(cfg_val[REG_SCALE]);
        if (need < 0) need = 0;
        if (need > 8191) need = 8191;
        return 13'(need);
    endfunction

    task automatic send_request(input t_request req);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {4'd0, req.ext, req.stand, req.amb, req.adc};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_status_q.push_back(predict_controller(req));
    endtask

    task automatic send_tick(input logic [1:0] ext);
        t_request req;
        req.op = OP_TICK;
        req.adc = 13'($urandom);
        req.amb = 12'($urandom);
        req.stand = 1'($urandom);
        req.ext = ext;
        send_request(req);
    endtask

    task automatic send_sample(input logic [12:0] adc, input logic signed [11:0] amb,
                               input logic stand, input logic [1:0] ext);
        t_request req;
        req.op = OP_SAMPLE;
        req.adc = adc;
        req.amb = amb;
        req.stand = stand;
        req.ext = ext;
        send_request(req);
    endtask

    task automatic tick_until(input logic [1:0] ph);
        for (int k = 0; k < 2100 && m_phase != ph; k++) send_tick(2'd0);
    endtask

    task automatic ready_for_sample();
        if (m_phase == PH_HEAT) tick_until(PH_READ);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (predicted_status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_val[idx] = val & reg_mask(idx);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg_plan();
        for (int i = 0; i < 8; i++) write_reg(3'(i), cfg_plan[i]);
    endtask

    task automatic send_random_request(output bit counted);
        t_request req;
        int       tgt, aim, sample_pct;
        req.stand = 1'($urandom);
        req.ext = ($urandom_range(99) < 6) ? 2'($urandom_range(1, 3)) : 2'd0;
        if ($urandom_range(9) == 0) req.amb = 12'($urandom);
        else req.amb = 12'(int'($urandom_range(0, 2624)) - 1024);
        case (m_phase)
            PH_READ: sample_pct = 85;
            PH_IDLE: sample_pct = 15;
            default: sample_pct = 5;
        endcase
        if ($urandom_range(9) == 0) req.op = 1'($urandom);
        else req.op = ($urandom_range(99) < sample_pct) ? OP_SAMPLE : OP_TICK;
        aim = req.stand ? int'(cfg_val[REG_STAND_TEMP]) : int'(cfg_val[REG_SETPOINT]);
        if ($urandom_range(1) == 0) tgt = aim + int'($urandom_range(0, 800)) - 400;
        else tgt = $urandom_range(80, 6880);
        if (tgt < 80) tgt = 80;
        if (tgt > 6880) tgt = 6880;
        if (req.op == OP_SAMPLE && $urandom_range(7) != 0) req.adc = adc_for(tgt, req.amb);
        else req.adc = 13'($urandom);
        counted = !(req.op == OP_SAMPLE && m_phase == PH_HEAT && req.ext == 2'd0);
        send_request(req);
    endtask

    task automatic test_power_on();
        send_tick(2'd0);
        send_sample(adc_for(3000, 12'sd0), 12'sd0, 1'b0, 2'd0);
        send_sample(adc_for(2500, 12'sd320), 12'sd320, 1'b0, 2'd0);
    endtask

    task automatic test_phase_cycle();
        write_reg(REG_HALF_CYC, 18'd2);
        tick_until(PH_HEAT);
        // sample while heating is dropped
        send_sample(adc_for(3000, 12'sd0), 12'sd0, 1'b0, 2'd0);
        tick_until(PH_READ);
        send_sample(13'h1FFF, 12'sh7FF, 1'b0, 2'd0);
        send_tick(2'd0);
        send_tick(2'd0);
        ready_for_sample();
        send_sample(adc_for(5000, -12'sd1024), -12'sd1024, 1'b1, 2'd0);
    endtask

    task automatic test_ext_faults();
        tick_until(PH_HEAT);
        send_tick(2'd1);
        send_sample(adc_for(4000, 12'sd100), 12'sd100, 1'b0, 2'd2);
        send_tick(2'd3);
        send_tick(2'd0);
        send_tick(2'd0);
        send_tick(2'd2);
    endtask

    task automatic test_extreme_settings();
        write_reg(REG_SCALE, 18'h3FFFF);
        write_reg(REG_SETPOINT, 18'h3FFFF);
        write_reg(REG_STAND_TEMP, 18'd0);
        write_reg(REG_GAIN_P, 18'h0FFFF);
        write_reg(REG_GAIN_I, 18'h0FFFF);
        write_reg(REG_GAIN_D, 18'h0FFFF);
        write_reg(REG_INTEG_CAP, 18'h3FFFF);
        ready_for_sample();
        send_sample(13'h1FFF, 12'sh7FF, 1'b0, 2'd0);
        ready_for_sample();
        send_sample(13'd0, 12'sh800, 1'b0, 2'd0);
        ready_for_sample();
        send_sample(adc_for(100, 12'sd0), 12'sd0, 1'b0, 2'd0);
        ready_for_sample();
        send_sample(adc_for(6800, 12'sd0), 12'sd0, 1'b1, 2'd0);
        write_reg(REG_GAIN_P, 18'd0);
        write_reg(REG_GAIN_I, 18'd0);
        write_reg(REG_GAIN_D, 18'd0);
        ready_for_sample();
        send_sample(adc_for(1000, 12'sd0), 12'sd0, 1'b0, 2'd0);
        // zero period length
        write_reg(REG_HALF_CYC, 18'd0);
        repeat (4) send_tick(2'd0);
    endtask

    task automatic test_random_traffic();
        int done;
        bit counted, paused;
        for (int round = 0; round < 8; round++) begin
            case (round % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            case (round)
                0: begin
                    cfg_plan[REG_SETPOINT] = 18'd5600;
                    cfg_plan[REG_STAND_TEMP] = 18'd2400;
                    cfg_plan[REG_GAIN_P] = 18'd256;
                    cfg_plan[REG_GAIN_I] = 18'd51;
                    cfg_plan[REG_GAIN_D] = 18'd51;
                    cfg_plan[REG_INTEG_CAP] = 18'd1600;
                    cfg_plan[REG_HALF_CYC] = 18'd100;
                    cfg_plan[REG_SCALE] = 18'd121563;
                end
                1: for (int i = 0; i < 8; i++) cfg_plan[i] = 18'h3FFFF;
                2: for (int i = 0; i < 8; i++) cfg_plan[i] = 18'd0;
                default: begin
                    cfg_plan[REG_SETPOINT] = 18'($urandom_range(0, 8191));
                    cfg_plan[REG_STAND_TEMP] = 18'($urandom_range(0, 8191));
                    cfg_plan[REG_GAIN_P] = 18'(($urandom_range(3) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(0, 600));
                    cfg_plan[REG_GAIN_I] = 18'(($urandom_range(3) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(0, 600));
                    cfg_plan[REG_GAIN_D] = 18'(($urandom_range(3) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(0, 600));
                    cfg_plan[REG_INTEG_CAP] = 18'(($urandom_range(3) == 0) ?
                        $urandom_range(0, 32767) : $urandom_range(0, 3000));
                    cfg_plan[REG_HALF_CYC] = 18'(($urandom_range(6) == 0) ?
                        $urandom_range(0, 1023) : $urandom_range(1, 24));
                    cfg_plan[REG_SCALE] = 18'(($urandom_range(4) == 0) ?
                        $urandom_range(0, 262143) : $urandom_range(60000, 200000));
                    for (int i = 0; i < 8; i++)
                        if ($urandom_range(9) == 0)
                            cfg_plan[i] = cfg_plan[i] | (18'($urandom) & ~reg_mask(3'(i)));
                end
            endcase
            apply_cfg_plan();
            done = 0;
            paused = 1'b0;
            while (done < ITEMS_PER_ROUND) begin
                if (!paused && done == ITEMS_PER_ROUND / 2) begin
                    wait_drain();
                    paused = 1'b1;
                end
                send_random_request(counted);
                if (counted) done++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : check_result
        t_status got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.heater = m_axis_tdata[0];
            got.phase  = m_axis_tdata[2:1];
            got.power  = m_axis_tdata[13:3];
            got.temp   = m_axis_tdata[29:14];
            got.faults = m_axis_tdata[32:30];
            got.used   = m_axis_tdata[33];
            if (predicted_status_q.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                err_count++;
            end else begin
                want = predicted_status_q.pop_front();
                if (got.heater !== want.heater) begin
                    $error("heater_on: expected %0d, got %0d", want.heater, got.heater);
                    err_count++;
                end
                if (got.phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, got.phase);
                    err_count++;
                end
                if (got.power !== want.power) begin
                    $error("power_level: expected %0d, got %0d", want.power, got.power);
                    err_count++;
                end
                if (got.temp !== want.temp) begin
                    $error("measured_temp: expected %0d, got %0d", want.temp, got.temp);
                    err_count++;
                end
                if (got.faults !== want.faults) begin
                    $error("fault_bits: expected %0d, got %0d", want.faults, got.faults);
                    err_count++;
                end
                if (got.used !== want.used) begin
                    $error("sample_used: expected %0d, got %0d", want.used, got.used);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_val[REG_SETPOINT]   = 18'd5600;
        cfg_val[REG_STAND_TEMP] = 18'd2400;
        cfg_val[REG_GAIN_P]     = 18'd256;
        cfg_val[REG_GAIN_I]     = 18'd51;
        cfg_val[REG_GAIN_D]     = 18'd51;
        cfg_val[REG_INTEG_CAP]  = 18'd1600;
        cfg_val[REG_HALF_CYC]   = 18'd100;
        cfg_val[REG_SCALE]      = 18'd121563;
        m_phase = PH_HEAT;
        m_count = 0;
        m_power = 0;
        m_integ = 0;
        m_last_err = 0;
        m_temp = 0;
        m_rdfault = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on();
        test_phase_cycle();
        test_ext_faults();
        test_extreme_settings();
        test_random_traffic();
        wait_drain();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[burst_fire_pid_heater_controller.f]
sv/bfpid_pkg.sv
sv/bfpid_mul.sv
sv/burst_fire_pid_heater_controller.sv
test/tb_burst_fire_pid_heater_controller.sv
